[hdl/hvd_pkg.sv]
// ----------------------------------------------------------------------------
// hvd_pkg
// Shared widths, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package hvd_pkg;

  localparam int LatW    = 31;
  localparam int LonW    = 32;
  localparam int RadW    = 23;
  localparam int DistW   = 31;
  localparam int CordW   = 36;  // CORDIC datapath width, Q5.30 signed
  localparam int DefIter = 24;

  localparam logic signed [CordW-1:0] OneQ30    = 36'sd1073741824;
  localparam logic signed [CordW-1:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [CordW-1:0] GainQ30   = 36'sd652032874;
  localparam logic [31:0]             PiQ30     = 32'd3373259426;
  localparam longint                  QuarterTurn = 64'sd900000000;
  localparam longint                  HalfTurn    = 64'sd1800000000;
  localparam longint                  FullTurn    = 64'sd3600000000;
  localparam longint                  FullDiv     = 64'sd1800000000;
  localparam longint                  HalfDiv     = 64'sd3600000000;
  localparam logic [22:0]             RadReset    = 23'd6371000;

  // arctangent of 2^-i in Q2.30
  function automatic logic signed [CordW-1:0] atan_q30(input int i);
    logic signed [CordW-1:0] t;
    case (i)
      0: t = 36'sd843314856;  1: t = 36'sd497837829;
      2: t = 36'sd263043836;  3: t = 36'sd133525158;
      4: t = 36'sd67021686;   5: t = 36'sd33543515;
      6: t = 36'sd16775850;   7: t = 36'sd8388437;
      8: t = 36'sd4194282;    9: t = 36'sd2097149;
      default: t = (i >= 31) ? 36'sd0 : (36'sd1 <<< (30 - i));
    endcase
    return t;
  endfunction

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [CordW-1:0] z;
  } cord_t;

endpackage

[hdl/hvd_cordic.sv]
// ----------------------------------------------------------------------------
// hvd_cordic
// Unrolled, fully pipelined CORDIC; rotation or vectoring mode, one stage per
// iteration, with an enable shared by all stages.
// ----------------------------------------------------------------------------
module hvd_cordic #(
  parameter int ITER      = hvd_pkg::DefIter,
  parameter bit VECTORING = 1'b0
) (
  input  logic          clk,
  input  logic          en,
  input  hvd_pkg::cord_t din,
  output hvd_pkg::cord_t dout
);

  hvd_pkg::cord_t stg_r [ITER+1];

  assign stg_r[0] = din;

  // one micro-rotation per stage
  for (genvar i = 0; i < ITER; i++) begin : g_stage
    hvd_pkg::cord_t s_nxt;
    logic           dir;
    always_comb begin
      dir = VECTORING ? (stg_r[i].y > 0) : (stg_r[i].z >= 0);
      if (dir ^ VECTORING) begin
        s_nxt.x = stg_r[i].x - (stg_r[i].y >>> i);
        s_nxt.y = stg_r[i].y + (stg_r[i].x >>> i);
        s_nxt.z = stg_r[i].z - hvd_pkg::atan_q30(i);
      end else begin
        s_nxt.x = stg_r[i].x + (stg_r[i].y >>> i);
        s_nxt.y = stg_r[i].y - (stg_r[i].x >>> i);
        s_nxt.z = stg_r[i].z + hvd_pkg::atan_q30(i);
      end
    end
    hvd_pkg::cord_t s_r;
    always_ff @(posedge clk) begin
      if (en) s_r <= s_nxt;
    end
    assign stg_r[i+1] = s_r;
  end

  assign dout = stg_r[ITER];

endmodule

[hdl/haversine_distance_top.sv]
// ----------------------------------------------------------------------------
// haversine_distance_top
// Great-circle distance between two points by the haversine formula.
// ----------------------------------------------------------------------------
// Input channel in_*: two lat/lon points in 1e-7 degree. Output channel out_*:
// distance in centimeters and a flag set when h came out above one.
// Configuration channel cfg_*: sphere radius in meters, reset 6371000; write
// only while no item is in flight.
// The block is one pipeline of 2*CORDIC_ITERATIONS+41 stages (iterations capped
// at 32): angle scaling (4 stages), a rotation CORDIC (sin/cos), three product
// and clamp stages, two pipelined 32-stage square roots run in parallel, a
// vectoring CORDIC and the scale multiply (2 stages). An item enters every cycle
// while the output is not stalled; out_valid rises as it reaches the last stage.
// The whole pipeline advances together when the output register is empty or
// taken, so a stalled receiver freezes every stage and nothing is lost.
// Reset clears all valid bits and restores the radius.
// ----------------------------------------------------------------------------
module haversine_distance_top #(
  parameter int CORDIC_ITERATIONS = hvd_pkg::DefIter
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [hvd_pkg::LatW-1:0]  in_start_lat,
  input  logic signed [hvd_pkg::LonW-1:0]  in_start_lon,
  input  logic signed [hvd_pkg::LatW-1:0]  in_end_lat,
  input  logic signed [hvd_pkg::LonW-1:0]  in_end_lon,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hvd_pkg::DistW-1:0]        out_distance_cm,
  output logic                             out_range_error,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hvd_pkg::RadW-1:0]         cfg_earth_radius_m
);

  localparam int It = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
  localparam int Cw = hvd_pkg::CordW;
  // stages before the CORDIC, inside it, between, sqrt, second CORDIC, after
  localparam int NS  = 4 + It + 3 + 32 + It + 2;

  // turn lengths and scaled reciprocals of pi over them (Q32)
  localparam logic [63:0] DHalf = 64'(hvd_pkg::HalfDiv);
  localparam logic [63:0] DFull = 64'(hvd_pkg::FullDiv);
  localparam logic [63:0] KHalf = (64'(hvd_pkg::PiQ30) << 32) / DHalf;
  localparam logic [63:0] KFull = (64'(hvd_pkg::PiQ30) << 32) / DFull;

  logic en;
  logic [NS-1:0] vld_r;
  assign en       = !vld_r[NS-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld_r[NS-1];
  assign cfg_ready = 1'b1;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[NS-2:0], in_valid};
  end

  logic [hvd_pkg::RadW-1:0] radius_r;
  always_ff @(posedge clk) begin
    if (!rst_n) radius_r <= hvd_pkg::RadReset;
    else if (cfg_valid) radius_r <= cfg_earth_radius_m;
  end

  // ---- stage 1: angle differences, wraps, quadrant folds
  logic signed [33:0] a_nxt [4];
  logic [3:0]         flip_nxt;
  always_comb begin
    longint l1, l2, d1, d2;
    l1 = longint'(in_start_lat); l2 = longint'(in_end_lat);
    d1 = l1 - l2;
    d2 = longint'(in_end_lon) - longint'(in_start_lon);
    if (d1 > hvd_pkg::HalfTurn) d1 = d1 - hvd_pkg::FullTurn;
    else if (d1 < -hvd_pkg::HalfTurn) d1 = d1 + hvd_pkg::FullTurn;
    if (d2 > hvd_pkg::HalfTurn) d2 = d2 - hvd_pkg::FullTurn;
    else if (d2 < -hvd_pkg::HalfTurn) d2 = d2 + hvd_pkg::FullTurn;
    flip_nxt = '0;
    if (l1 > hvd_pkg::QuarterTurn) begin l1 = hvd_pkg::HalfTurn - l1; flip_nxt[2] = 1'b1; end
    else if (l1 < -hvd_pkg::QuarterTurn) begin l1 = -hvd_pkg::HalfTurn - l1; flip_nxt[2] = 1'b1; end
    if (l2 > hvd_pkg::QuarterTurn) begin l2 = hvd_pkg::HalfTurn - l2; flip_nxt[3] = 1'b1; end
    else if (l2 < -hvd_pkg::QuarterTurn) begin l2 = -hvd_pkg::HalfTurn - l2; flip_nxt[3] = 1'b1; end
    a_nxt[0] = d1[33:0]; a_nxt[1] = d2[33:0];
    a_nxt[2] = l1[33:0]; a_nxt[3] = l2[33:0];
  end

  logic [31:0] mag_r [4];
  logic [3:0]  neg_r, flip1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        neg_r[k] <= a_nxt[k][33];
        mag_r[k] <= a_nxt[k][33] ? 32'(-a_nxt[k]) : a_nxt[k][31:0];
      end
      flip1_r <= flip_nxt;
    end
  end

  // ---- stage 2: magnitude times pi plus half a turn length, quotient estimate
  logic [63:0] prod_r [4];
  logic [31:0] q0_r [4];
  logic [3:0]  neg2_r, flip2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        logic [63:0] e;
        e = 64'(mag_r[k]) * ((k < 2) ? KHalf : KFull);
        q0_r[k]   <= e[63:32];
        prod_r[k] <= 64'(mag_r[k]) * 64'(hvd_pkg::PiQ30) + (((k < 2) ? DHalf : DFull) >> 1);
      end
      neg2_r <= neg_r; flip2_r <= flip1_r;
    end
  end

  // ---- stage 3: remainder left by the estimate (it is low by at most one)
  logic [63:0] rem_r [4];
  logic [31:0] q1_r [4];
  logic [3:0]  neg3_r, flip3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        rem_r[k] <= prod_r[k] - 64'(q0_r[k]) * ((k < 2) ? DHalf : DFull);
        q1_r[k]  <= q0_r[k];
      end
      neg3_r <= neg2_r; flip3_r <= flip2_r;
    end
  end

  // ---- stage 4: correct the quotient, restore the sign
  hvd_pkg::cord_t cin [4];
  logic [3:0]     flip4_r;
  logic signed [Cw-1:0] z_r [4];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        logic [31:0] q;
        q = q1_r[k] + 32'(rem_r[k] >= ((k < 2) ? DHalf : DFull));
        z_r[k] <= neg3_r[k] ? -Cw'(q) : Cw'(q);
      end
      flip4_r <= flip3_r;
    end
  end

  // ---- rotation CORDICs: half-angle sines and latitude cosines
  hvd_pkg::cord_t cout_w [4];
  for (genvar k = 0; k < 4; k++) begin : g_rot
    assign cin[k] = '{x: hvd_pkg::GainQ30, y: '0, z: z_r[k]};
    hvd_cordic #(.ITER(It), .VECTORING(1'b0)) u_rot (
      .clk(clk), .en(en), .din(cin[k]), .dout(cout_w[k]));
  end

  logic [1:0] flipd_r [It];
  always_ff @(posedge clk) begin
    if (en) begin
      flipd_r[0] <= flip4_r[3:2];
      for (int k = 1; k < It; k++) flipd_r[k] <= flipd_r[k-1];
    end
  end

  function automatic logic signed [Cw-1:0] clamp1(input logic signed [Cw-1:0] v);
    if (v > hvd_pkg::OneQ30) return hvd_pkg::OneQ30;
    if (v < -hvd_pkg::OneQ30) return -hvd_pkg::OneQ30;
    return v;
  endfunction

  // ---- product stage A: squares and cosine product
  logic signed [31:0] s1sq_r, s2sq_r, p_r;
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [31:0] s1, s2, c1, c2;
      logic signed [63:0] m;
      s1 = 32'(clamp1(cout_w[0].y)); s2 = 32'(clamp1(cout_w[1].y));
      c1 = 32'(clamp1(cout_w[2].x)); c2 = 32'(clamp1(cout_w[3].x));
      if (flipd_r[It-1][0]) c1 = -c1;
      if (flipd_r[It-1][1]) c2 = -c2;
      m = 64'(s1) * 64'(s1); s1sq_r <= 32'(m >>> 30);
      m = 64'(s2) * 64'(s2); s2sq_r <= 32'(m >>> 30);
      m = 64'(c1) * 64'(c2); p_r    <= 32'(m >>> 30);
    end
  end

  // ---- product stage B: h
  logic signed [33:0] h_r;
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [63:0] m;
      m = 64'(p_r) * 64'(s2sq_r);
      h_r <= 34'(s1sq_r) + 34'(m >>> 30);
    end
  end

  // ---- clamp stage: h into [0, 1]
  logic [61:0] ra_r [33], rb_r [33], va_r [33], vb_r [33];
  logic        err_r [33];
  always_ff @(posedge clk) begin
    if (en) begin
      logic [30:0] hc;
      if (h_r > 34'(hvd_pkg::OneQ30)) hc = 31'(hvd_pkg::OneQ30);
      else if (h_r < 0) hc = '0;
      else hc = 31'(h_r);
      err_r[0] <= (h_r > 34'(hvd_pkg::OneQ30));
      va_r[0] <= {hc, 30'd0, 1'b0} >> 1;
      vb_r[0] <= {31'(hvd_pkg::OneQ30) - hc, 30'd0, 1'b0} >> 1;
      ra_r[0] <= '0; rb_r[0] <= '0;
    end
  end

  // ---- square roots: one result bit per stage, 31 stages plus one
  for (genvar j = 0; j < 32; j++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (en) begin
        logic [61:0] b;
        b = 62'd1 << (2 * (30 - j));
        if (j > 30) begin
          ra_r[j+1] <= ra_r[j]; rb_r[j+1] <= rb_r[j];
          va_r[j+1] <= va_r[j]; vb_r[j+1] <= vb_r[j];
        end else begin
          if (va_r[j] >= ra_r[j] + b) begin
            va_r[j+1] <= va_r[j] - (ra_r[j] + b); ra_r[j+1] <= (ra_r[j] >> 1) + b;
          end else begin
            va_r[j+1] <= va_r[j]; ra_r[j+1] <= ra_r[j] >> 1;
          end
          if (vb_r[j] >= rb_r[j] + b) begin
            vb_r[j+1] <= vb_r[j] - (rb_r[j] + b); rb_r[j+1] <= (rb_r[j] >> 1) + b;
          end else begin
            vb_r[j+1] <= vb_r[j]; rb_r[j+1] <= rb_r[j] >> 1;
          end
        end
        err_r[j+1] <= err_r[j];
      end
    end
  end

  // ---- vectoring CORDIC: asin(sqrt h) = atan(a / b)
  hvd_pkg::cord_t vin, vout;
  assign vin = '{x: Cw'(rb_r[32]), y: Cw'(ra_r[32]), z: '0};
  hvd_cordic #(.ITER(It), .VECTORING(1'b1)) u_vec (
    .clk(clk), .en(en), .din(vin), .dout(vout));

  logic errv_r [It];
  always_ff @(posedge clk) begin
    if (en) begin
      errv_r[0] <= err_r[32];
      for (int k = 1; k < It; k++) errv_r[k] <= errv_r[k-1];
    end
  end

  // ---- scale stage 1: clamp angle, radius times 200
  logic [30:0] ang_r;
  logic [30:0] r200_r;
  logic        err_s_r;
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [Cw-1:0] z;
      z = vout.z;
      if (z < 0) z = '0;
      if (z > hvd_pkg::HalfPiQ30) z = hvd_pkg::HalfPiQ30;
      ang_r   <= 31'(z);
      r200_r  <= 31'(radius_r) * 31'd200;
      err_s_r <= errv_r[It-1];
    end
  end

  // ---- scale stage 2: multiply, round, saturate
  logic [hvd_pkg::DistW-1:0] dist_r;
  logic                      err_o_r;
  always_ff @(posedge clk) begin
    if (en) begin
      logic [63:0] d;
      d = (64'(r200_r) * 64'(ang_r) + (64'd1 << 29)) >> 30;
      dist_r  <= (d > 64'h7FFFFFFF) ? '1 : 31'(d);
      err_o_r <= err_s_r;
    end
  end

  assign out_distance_cm = dist_r;
  assign out_range_error = err_o_r;

  // ---- checks
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance_cm))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("pipeline stalled while empty");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distance_cm <= 31'd2010619298 || radius_r > 23'd6400000)
    else $error("distance beyond half circumference");

endmodule
